// ===== rtl/radio_collision_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// radio_collision_tracker_core_defines
// Assertion macros used by the checker file of the tracker.
// ----------------------------------------------------------------------------
`ifndef RADIO_COLLISION_TRACKER_CORE_DEFINES_SVH
`define RADIO_COLLISION_TRACKER_CORE_DEFINES_SVH

// concurrent assertion, off while reset is high
`define RCT_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion, also checked across reset
`define RCT_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Types, codes and sizes of the radio collision tracker.
// ----------------------------------------------------------------------------
package rct_pkg;

   localparam int MAX_ACTIVE_DEFAULT = 16;
   localparam int ID_W               = 8;
   localparam int COORD_W            = 12;
   localparam int POS_W              = 2 * COORD_W;
   localparam int COUNT_OUT_W        = 5;

   localparam logic [1:0] REQ_REGISTER = 2'd0;
   localparam logic [1:0] REQ_QUERY    = 2'd1;
   localparam logic [1:0] REQ_STOP     = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [ID_W-1:0]    tx_handle;
      logic [ID_W-1:0]    sender_id;
      logic [ID_W-1:0]    receiver_id;
      logic [COORD_W-1:0] sender_x;
      logic [COORD_W-1:0] sender_y;
      logic [COORD_W-1:0] receiver_x;
      logic [COORD_W-1:0] receiver_y;
      logic [COORD_W-1:0] sender_co_range;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   feasible;
      logic                   new_collided;
      logic [COUNT_OUT_W-1:0] active_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ID_W-1:0]    handle;
      logic [ID_W-1:0]    sender;
      logic [ID_W-1:0]    receiver;
      logic [POS_W-1:0]   sender_pos;
      logic [POS_W-1:0]   receiver_pos;
      logic [COORD_W-1:0] co_range;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_REPLY
   } state_type;

endpackage

// ===== rtl/rct_req_if.sv =====
// ----------------------------------------------------------------------------
// rct_req_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface rct_req_if;
   logic                  valid;
   logic                  ready;
   rct_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rct_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rct_rsp_if
// Response channel: valid, ready and one response item.
// ----------------------------------------------------------------------------
interface rct_rsp_if;
   logic                  valid;
   logic                  ready;
   rct_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/radio_collision_tracker_core.sv =====
// ----------------------------------------------------------------------------
// radio_collision_tracker_core
// Table of transmissions on the air with collision marking, feasibility
// query and removal by handle. One table walk per request through a single
// read port and one shared squared-distance compare unit.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   rct_pkg::req_item_type
//   rsp_chan  out  valid/ready   rct_pkg::rsp_item_type
//
// Register reads each entry once, pausing reads while one is in flight;
// each valid entry of another sender visits the distance unit twice. Query
// and stop make one table read per cycle. Register on a full table and the
// unused request code skip the walk and go straight to the reply state. One
// request at a time; the next is taken while the previous response waits in
// the output register; reset clears valid bits and count with no clearing pass.
// ----------------------------------------------------------------------------
module radio_collision_tracker_core #(
   parameter int MAX_ACTIVE = rct_pkg::MAX_ACTIVE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rct_req_if.sink   req_chan,
   rct_rsp_if.source rsp_chan
);

   localparam int IDX_W     = $clog2(MAX_ACTIVE);
   localparam int CNT_W     = $clog2(MAX_ACTIVE + 1);
   localparam int CW        = rct_pkg::COORD_W;
   localparam int PW        = rct_pkg::POS_W;
   localparam int SQ_W      = 2 * CW;
   localparam int OUT_CNT_W = rct_pkg::COUNT_OUT_W;

   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ACTIVE);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
   localparam logic [IDX_W:0]   ISSUE_END = (IDX_W + 1)'(MAX_ACTIVE);
   localparam logic [IDX_W:0]   ISSUE_ONE = (IDX_W + 1)'(1);

   localparam logic CHECK_NEW_RX = 1'b0;
   localparam logic CHECK_OLD_RX = 1'b1;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   rct_pkg::state_type     state_ff, state_in;
   rct_pkg::req_item_type  req_ff;
   rct_pkg::entry_type     mem [MAX_ACTIVE];
   rct_pkg::entry_type     rd_entry_ff;
   rct_pkg::rsp_item_type  rsp_data_ff, rsp_data_in;

   logic [IDX_W:0]         issue_ff;
   logic [IDX_W-1:0]       rd_tag_ff;
   logic                   rd_vld_ff;
   logic                   b_pend_ff;
   logic [MAX_ACTIVE-1:0]  valid_ff;
   logic [MAX_ACTIVE-1:0]  collided_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   col_ff, match_ff, found_ff, full_ff, slot_found_ff;
   logic [IDX_W-1:0]       slot_ff;
   logic                   rsp_valid_ff;

   logic                   u1_vld_ff, u1_kind_ff;
   logic [IDX_W-1:0]       u1_tag_ff;
   logic [CW-1:0]          u1_dx_ff, u1_dy_ff, u1_r_ff;
   logic                   u2_vld_ff, u2_kind_ff;
   logic [IDX_W-1:0]       u2_tag_ff;
   logic [SQ_W:0]          u2_sum_ff;
   logic [SQ_W-1:0]        u2_rsq_ff;

   logic                   accept, issue, issue_done, is_reg, is_query, is_stop;
   logic                   commit, can_load, drained;
   logic                   entry_live, feed_a, feed_b, q_hit, s_hit, free_hit, hit;
   logic [PW-1:0]          op_pa, op_pb, new_spos, new_rpos;
   logic [CW-1:0]          op_r;
   logic [SQ_W-1:0]        dx_sq, dy_sq, r_sq;
   rct_pkg::entry_type     new_entry;

   assign is_reg   = (req_ff.req_type == rct_pkg::REQ_REGISTER);
   assign is_query = (req_ff.req_type == rct_pkg::REQ_QUERY);
   assign is_stop  = (req_ff.req_type == rct_pkg::REQ_STOP);
   assign new_spos = {req_ff.sender_x, req_ff.sender_y};
   assign new_rpos = {req_ff.receiver_x, req_ff.receiver_y};

   assign issue_done = (issue_ff == ISSUE_END);
   assign drained    = !rd_vld_ff && !b_pend_ff && !u1_vld_ff && !u2_vld_ff;
   assign can_load   = !rsp_valid_ff || rsp_chan.ready;

   assign entry_live = valid_ff[rd_tag_ff] && (rd_entry_ff.sender != req_ff.sender_id);
   assign feed_a     = rd_vld_ff && is_reg && entry_live;
   assign feed_b     = b_pend_ff;
   assign q_hit      = rd_vld_ff && is_query && valid_ff[rd_tag_ff]
                       && (rd_entry_ff.sender == req_ff.sender_id)
                       && (rd_entry_ff.receiver == req_ff.receiver_id)
                       && !collided_ff[rd_tag_ff];
   assign s_hit      = rd_vld_ff && is_stop && valid_ff[rd_tag_ff]
                       && (rd_entry_ff.handle == req_ff.tx_handle);
   assign free_hit   = rd_vld_ff && is_reg && !valid_ff[rd_tag_ff] && !slot_found_ff;
   assign hit        = u2_vld_ff && (u2_sum_ff < {1'b0, u2_rsq_ff});

   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      issue    = 1'b0;
      commit   = 1'b0;
      case (state_ff)
         rct_pkg::ST_IDLE: begin
            accept = req_chan.valid;
            if (req_chan.valid) begin
               if ((req_chan.data.req_type == rct_pkg::REQ_UNUSED) ||
                   ((req_chan.data.req_type == rct_pkg::REQ_REGISTER) &&
                    (count_ff == MAX_CNT))) begin
                  state_in = rct_pkg::ST_REPLY;
               end else begin
                  state_in = rct_pkg::ST_WALK;
               end
            end
         end
         rct_pkg::ST_WALK: begin
            if (issue_done) begin
               state_in = rct_pkg::ST_DRAIN;
            end else begin
               issue = !is_reg || !rd_vld_ff;
            end
         end
         rct_pkg::ST_DRAIN: begin
            if (drained) begin
               state_in = rct_pkg::ST_REPLY;
            end
         end
         rct_pkg::ST_REPLY: begin
            if (can_load) begin
               commit   = is_reg && !full_ff;
               state_in = rct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rct_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == rct_pkg::ST_IDLE);

   always_comb begin
      if (feed_b) begin
         op_pa = new_spos;
         op_pb = rd_entry_ff.receiver_pos;
         op_r  = req_ff.sender_co_range;
      end else begin
         op_pa = rd_entry_ff.sender_pos;
         op_pb = new_rpos;
         op_r  = rd_entry_ff.co_range;
      end
   end

   assign dx_sq = SQ_W'(u1_dx_ff) * SQ_W'(u1_dx_ff);
   assign dy_sq = SQ_W'(u1_dy_ff) * SQ_W'(u1_dy_ff);
   assign r_sq  = SQ_W'(u1_r_ff) * SQ_W'(u1_r_ff);

   always_comb begin
      count_in = count_ff;
      if (s_hit) begin
         count_in = count_ff - ONE_CNT;
      end else if (commit) begin
         count_in = count_ff + ONE_CNT;
      end
   end

   always_comb begin
      rsp_data_in.status = rct_pkg::STATUS_OK;
      if (full_ff) begin
         rsp_data_in.status = rct_pkg::STATUS_FULL;
      end else if (is_stop && !found_ff) begin
         rsp_data_in.status = rct_pkg::STATUS_NOT_FOUND;
      end
      rsp_data_in.feasible     = is_query && ((count_ff == ONE_CNT) || match_ff);
      rsp_data_in.new_collided = is_reg && !full_ff && col_ff;
      rsp_data_in.active_count = OUT_CNT_W'(count_in);
   end

   assign new_entry.handle       = req_ff.tx_handle;
   assign new_entry.sender       = req_ff.sender_id;
   assign new_entry.receiver     = req_ff.receiver_id;
   assign new_entry.sender_pos   = new_spos;
   assign new_entry.receiver_pos = new_rpos;
   assign new_entry.co_range     = req_ff.sender_co_range;

   always_ff @(posedge clock) begin
      if (commit) begin
         mem[slot_ff] <= new_entry;
      end
      if (issue) begin
         rd_entry_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rct_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         b_pend_ff    <= 1'b0;
         u1_vld_ff    <= 1'b0;
         u2_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         b_pend_ff <= feed_a;
         u1_vld_ff <= feed_a || feed_b;
         u2_vld_ff <= u1_vld_ff;
         count_ff  <= count_in;
         if (s_hit) begin
            valid_ff[rd_tag_ff] <= 1'b0;
         end
         if (commit) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         if (can_load && (state_ff == rct_pkg::ST_REPLY)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff        <= req_chan.data;
         issue_ff      <= '0;
         col_ff        <= 1'b0;
         match_ff      <= 1'b0;
         found_ff      <= 1'b0;
         slot_found_ff <= 1'b0;
         full_ff       <= (req_chan.data.req_type == rct_pkg::REQ_REGISTER)
                          && (count_ff == MAX_CNT);
      end else begin
         if (issue) begin
            issue_ff <= issue_ff + ISSUE_ONE;
         end
         if (hit && (u2_kind_ff == CHECK_NEW_RX)) begin
            col_ff <= 1'b1;
         end
         if (q_hit) begin
            match_ff <= 1'b1;
         end
         if (s_hit) begin
            found_ff <= 1'b1;
         end
         if (free_hit) begin
            slot_found_ff <= 1'b1;
            slot_ff       <= rd_tag_ff;
         end
      end
      if (issue) begin
         rd_tag_ff <= issue_ff[IDX_W-1:0];
      end
      if (hit && (u2_kind_ff == CHECK_OLD_RX)) begin
         collided_ff[u2_tag_ff] <= 1'b1;
      end
      if (commit) begin
         collided_ff[slot_ff] <= col_ff;
      end
      u1_kind_ff <= feed_b ? CHECK_OLD_RX : CHECK_NEW_RX;
      u1_tag_ff  <= rd_tag_ff;
      u1_dx_ff   <= abs_diff(op_pa[PW-1:CW], op_pb[PW-1:CW]);
      u1_dy_ff   <= abs_diff(op_pa[CW-1:0], op_pb[CW-1:0]);
      u1_r_ff    <= op_r;
      u2_kind_ff <= u1_kind_ff;
      u2_tag_ff  <= u1_tag_ff;
      u2_sum_ff  <= {1'b0, dx_sq} + {1'b0, dy_sq};
      u2_rsq_ff  <= r_sq;
      if (can_load && (state_ff == rct_pkg::ST_REPLY)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// ===== rtl/rct_checker.sv =====
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks of the radio collision tracker, bound to the tracker core.
// ----------------------------------------------------------------------------
`include "radio_collision_tracker_core_defines.svh"

module rct_checker #(
   parameter int MAX_ACTIVE = rct_pkg::MAX_ACTIVE_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rct_pkg::rsp_item_type rsp_data
);

   `RCT_ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data),
      "response item changed while stalled")

   `RCT_ASSERT_RST(a_busy_after_accept, clock, reset,
      req_valid && req_ready |=> !req_ready,
      "request taken while busy")

   `RCT_ASSERT_RST(a_flags_on_error, clock, reset,
      rsp_valid && (rsp_data.status != rct_pkg::STATUS_OK)
         |-> !rsp_data.feasible && !rsp_data.new_collided,
      "flags set on refused request")

   `RCT_ASSERT_RST(a_count_bound, clock, reset,
      rsp_valid |-> (MAX_ACTIVE > 31) || (rsp_data.active_count <= MAX_ACTIVE),
      "active count beyond table size")

   `RCT_ASSERT(a_reset_idle, clock, reset |=> !rsp_valid, "response pending after reset")

endmodule

bind radio_collision_tracker_core rct_checker #(
   .MAX_ACTIVE(MAX_ACTIVE)
) u_rct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
